[hw/rtl/bitmap_first_free_allocator_core_macros.svh]
// Assertion macros shared by the allocator checker.
// No dependencies; include by bare file name.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define FBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fba_pkg.sv]
// Shared types and constants for the bitmap first-free allocator.
// No dependencies.
package fba_pkg;

	localparam int FIELD_W   = 14;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;

	// actions
	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_FREE  = 1'd1;

	localparam logic [FIELD_W-1:0] CNT_MAX       = 14'h3FFF;
	localparam logic [FIELD_W-1:0] RST_ENTRY_CNT = 14'd8192;
	localparam logic [FIELD_W-1:0] RST_FREE_CNT  = 14'd8192;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [FIELD_W-1:0] entry_number;
	} req_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] granted_entry;
		logic [FIELD_W-1:0] free_left;
		logic [STAT_W-1:0]  status;
	} rsp_item_t;

endpackage

[hw/rtl/fba_map_ram.sv]
// Usage bitmap storage: one write port, one read port, registered read data.
// No dependencies.
module fba_map_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fba_first_zero.sv]
// Finds the lowest clear bit of a bitmap word among the bits still in range.
// No dependencies.
module fba_first_zero #(
	parameter int WORD_BITS = 32,
	parameter int BW        = 5
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [15:0]          bits_left,
	output logic                 found,
	output logic [BW-1:0]        bit_idx
);

	logic [WORD_BITS-1:0] avail;

	// bit i is eligible when free and below the managed count
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			avail[i] = !word[i] && (16'(i) < bits_left);
		end
	end

	// priority encode, lowest wins
	always_comb begin
		found   = 1'b0;
		bit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				found   = 1'b1;
				bit_idx = BW'(i);
			end
		end
	end

endmodule

[hw/rtl/bitmap_first_free_allocator_core.sv]
// Top level of the bitmap first-free allocator: control FSM, free counter, config.
// Depends on fba_pkg, fba_map_ram, fba_first_zero.
//
// channel | dir | signals                    | accepted when
// req     | in  | req_valid, req_ready, req  | req_valid && req_ready
// rsp     | out | rsp_valid, rsp_ready, rsp  | rsp_valid && rsp_ready
// cfg     | in  | cfg_we, cfg_index, cfg_data| cfg_we
//
// Allocate: bitmap words are read in order until the first free bit is found
// (one word read per cycle through the single RAM read port).
// Release and mark: index split, read, write back, respond;
// out-of-range, unused action or zero count: respond directly.
// After reset a clearing pass writes every bitmap word with
// req_ready low; config writes are taken during it.
// One item at a time; the next item is accepted while a result waits in rsp.
module bitmap_first_free_allocator_core
	import fba_pkg::*;
#(
	parameter int MAP_ENTRIES = 8192,
	parameter int WORD_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_item_t            req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_item_t            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int DIV_SHIFT = 20;
	localparam int DIV_RECIP = (1 << DIV_SHIFT) / WORD_BITS;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIX  = 3'd4;
	localparam logic [2:0] ST_MOD  = 3'd5;
	localparam logic [2:0] ST_RESP = 3'd6;

	logic [2:0]           state_q;
	logic [AW-1:0]        clr_addr_q;
	logic [AW-1:0]        iss_addr_q;
	logic [15:0]          iss_base_q;
	logic                 chk_vld_s1;
	logic [AW-1:0]        chk_addr_s1;
	logic [15:0]          chk_base_s1;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;
	logic [FIELD_W-1:0]   entry_count_q;
	logic [FIELD_W-1:0]   free_cnt_q;
	logic [ACT_W-1:0]     act_q;
	logic [FIELD_W-1:0]   idx_q;
	logic [FIELD_W-1:0]   q0_q;
	logic [AW-1:0]        wadr_q;
	logic [BW-1:0]        bit_q;
	logic [FIELD_W-1:0]   res_granted_q;
	logic [STAT_W-1:0]    res_status_q;

	logic [FIELD_W-1:0]   live_cnt;
	logic                 req_fire;
	logic                 num_bad;
	logic [15:0]          bits_left;
	logic                 word_last;
	logic                 hit;
	logic [BW-1:0]        hit_bit;
	logic                 scan_stop;
	logic                 scan_issue;
	logic [31:0]          div_prod;
	logic [15:0]          fix_rem;
	logic [FIELD_W-1:0]   fix_word;
	logic [15:0]          fix_bit;
	logic [WORD_BITS-1:0] hit_mask;
	logic [WORD_BITS-1:0] mod_mask;
	logic                 rsp_load;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// effective count, clamped to the map size
	always_comb begin
		if (32'(entry_count_q) > 32'(MAP_ENTRIES)) begin
			live_cnt = FIELD_W'(MAP_ENTRIES);
		end else begin
			live_cnt = entry_count_q;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign num_bad   = (req.entry_number == '0) || (req.entry_number > live_cnt);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	// scan check stage: word read last cycle against the count
	assign bits_left = 16'(live_cnt) - chk_base_s1;
	assign word_last = (chk_base_s1 + 16'(WORD_BITS)) >= 16'(live_cnt);

	fba_first_zero #(
		.WORD_BITS (WORD_BITS),
		.BW        (BW)
	) u_first_zero (
		.word      (mem_rdata),
		.bits_left (bits_left),
		.found     (hit),
		.bit_idx   (hit_bit)
	);

	assign scan_stop  = chk_vld_s1 && (hit || word_last);
	assign scan_issue = (state_q == ST_SCAN) && (iss_base_q < 16'(live_cnt)) && !scan_stop;

	// index split: reciprocal estimate, then one correction step
	assign div_prod = 32'(idx_q) * 32'(DIV_RECIP);
	always_comb begin
		fix_rem = 16'(idx_q) - 16'(q0_q) * 16'(WORD_BITS);
		if (fix_rem >= 16'(WORD_BITS)) begin
			fix_word = q0_q + 1'b1;
			fix_bit  = fix_rem - 16'(WORD_BITS);
		end else begin
			fix_word = q0_q;
			fix_bit  = fix_rem;
		end
	end

	assign hit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << hit_bit;
	assign mod_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q;

	// RAM port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			ST_SCAN: begin
				mem_re    = scan_issue;
				mem_raddr = iss_addr_q;
				if (chk_vld_s1 && hit) begin
					mem_we    = 1'b1;
					mem_waddr = chk_addr_s1;
					mem_wdata = mem_rdata | hit_mask;
				end
			end
			ST_FIX: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(fix_word);
			end
			ST_MOD: begin
				mem_we    = 1'b1;
				mem_waddr = wadr_q;
				if (act_q == ACT_RELEASE) begin
					mem_wdata = mem_rdata & ~mod_mask;
				end else begin
					mem_wdata = mem_rdata | mod_mask;
				end
			end
			default: begin
			end
		endcase
	end

	fba_map_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_map_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// config registers and free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= RST_ENTRY_CNT;
			free_cnt_q    <= RST_FREE_CNT;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENTRY_COUNT) begin
				entry_count_q <= cfg_data;
			end else if (cfg_index == CFG_START_FREE) begin
				free_cnt_q <= cfg_data;
			end
		end else if (state_q == ST_SCAN && chk_vld_s1 && hit) begin
			if (free_cnt_q != '0) begin
				free_cnt_q <= free_cnt_q - 1'b1;
			end
		end else if (state_q == ST_MOD && act_q == ACT_RELEASE) begin
			if (free_cnt_q != CNT_MAX) begin
				free_cnt_q <= free_cnt_q + 1'b1;
			end
		end
	end

	// control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			iss_addr_q  <= '0;
			iss_base_q  <= '0;
			chk_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= scan_issue;
			if (scan_issue) begin
				iss_addr_q <= iss_addr_q + 1'b1;
				iss_base_q <= iss_base_q + 16'(WORD_BITS);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						iss_addr_q <= '0;
						iss_base_q <= '0;
						if (req.action == ACT_ALLOC) begin
							state_q <= (live_cnt == '0) ? ST_RESP : ST_SCAN;
						end else if (req.action == ACT_RELEASE || req.action == ACT_MARK) begin
							state_q <= num_bad ? ST_RESP : ST_DIV;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (scan_stop) begin
						state_q <= ST_RESP;
					end
				end
				ST_DIV: state_q <= ST_FIX;
				ST_FIX: state_q <= ST_MOD;
				ST_MOD: state_q <= ST_RESP;
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		chk_addr_s1 <= iss_addr_q;
		chk_base_s1 <= iss_base_q;
		if (req_fire) begin
			act_q         <= req.action;
			idx_q         <= req.entry_number - 1'b1;
			res_granted_q <= '0;
			if (req.action == ACT_ALLOC) begin
				res_status_q <= (live_cnt == '0) ? STAT_NOFREE : STAT_OK;
			end else if (req.action == ACT_RELEASE || req.action == ACT_MARK) begin
				res_status_q <= num_bad ? STAT_RANGE : STAT_OK;
			end else begin
				res_status_q <= STAT_OK;
			end
		end
		if (state_q == ST_SCAN && scan_stop) begin
			if (hit) begin
				res_granted_q <= FIELD_W'(chk_base_s1 + 16'(hit_bit) + 16'd1);
				res_status_q  <= STAT_OK;
			end else begin
				res_status_q  <= STAT_NOFREE;
			end
		end
		if (state_q == ST_DIV) begin
			q0_q <= FIELD_W'(div_prod >> DIV_SHIFT);
		end
		if (state_q == ST_FIX) begin
			wadr_q <= AW'(fix_word);
			bit_q  <= BW'(fix_bit);
		end
		if (rsp_load) begin
			rsp_q.granted_entry <= res_granted_q;
			rsp_q.free_left     <= free_cnt_q;
			rsp_q.status        <= res_status_q;
		end
	end

endmodule

[hw/rtl/fba_checker.sv]
// Port-level checks for the allocator core, attached by bind.
// Depends on fba_pkg and bitmap_first_free_allocator_core_macros.svh.
`include "bitmap_first_free_allocator_core_macros.svh"

module fba_checker
	import fba_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp
);

	// a stalled result stays offered
	`FBA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

	// the unused status code is never produced
	`FBA_ASSERT_IMP(a_stat_legal, clk, arst_n, rsp_valid, rsp.status != STAT_UNUSED, "bad status")

	// a granted entry always comes with ok status
	`FBA_ASSERT_IMP(a_grant_ok, clk, arst_n, rsp_valid && rsp.granted_entry != '0,
		rsp.status == STAT_OK, "grant with error")

	// failures grant nothing
	`FBA_ASSERT_IMP(a_fail_zero, clk, arst_n, rsp_valid && rsp.status != STAT_OK,
		rsp.granted_entry == '0, "error with grant")

endmodule

bind bitmap_first_free_allocator_core fba_checker u_fba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
